// ===== rtl/polar_complex_alu_macros.svh =====
// Assertion macros shared by the checker of the polar complex ALU.
// Each macro expects a signal named clk in the scope that uses it; PCA_AS_IMP and PCA_AS_NXT also expect rst.
`ifndef POLAR_COMPLEX_ALU_MACROS_SVH
`define POLAR_COMPLEX_ALU_MACROS_SVH

`define PCA_AS_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("polar_complex_alu assertion failed");

`define PCA_AS_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("polar_complex_alu assertion failed");

`define PCA_AS_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("polar_complex_alu assertion failed");

`endif

// ===== rtl/pca_pkg.sv =====
// Shared types, codes and constants of the polar complex ALU.
// No dependencies; the gain, CORDIC, front end, back end, top level and checker import this package.
`default_nettype none
package pca_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ATAN_COUNT = 24;
  localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CART = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    K_ZERO  = 2'd0,
    K_CART  = 2'd1,
    K_SUM   = 2'd2,
    K_POLAR = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  div0;
    logic  sat;
  } cls_t;

  function automatic logic [31:0] atan_at(input int i);
    logic [31:0] a;
    unique case (i)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pca_if.sv =====
// Request and result channel interfaces of the polar complex ALU.
// Depend on nothing; the modulus and angle widths follow the interface parameters.
`default_nettype none
interface pca_req_if #(parameter int MOD_WIDTH = 32, parameter int ANGLE_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic [2:0]                    req_type;
  logic [MOD_WIDTH-1:0]          x_mod;
  logic signed [ANGLE_WIDTH-1:0] x_angle;
  logic [MOD_WIDTH-1:0]          y_mod;
  logic signed [ANGLE_WIDTH-1:0] y_angle;
  logic signed [MOD_WIDTH-1:0]   cart_re;
  logic signed [MOD_WIDTH-1:0]   cart_im;
  modport source (output valid, req_type, x_mod, x_angle, y_mod, y_angle, cart_re, cart_im,
                  input ready);
  modport sink (input valid, req_type, x_mod, x_angle, y_mod, y_angle, cart_re, cart_im,
                output ready);
endinterface

interface pca_res_if #(parameter int MOD_WIDTH = 32, parameter int ANGLE_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic [MOD_WIDTH-1:0]          res_mod;
  logic signed [ANGLE_WIDTH-1:0] res_angle;
  logic signed [MOD_WIDTH-1:0]   res_re;
  logic signed [MOD_WIDTH-1:0]   res_im;
  logic [1:0]                    status;
  modport source (output valid, res_mod, res_angle, res_re, res_im, status, input ready);
  modport sink (input valid, res_mod, res_angle, res_re, res_im, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/pca_gain.sv =====
// Two-stage multiply by the CORDIC gain constant, keeping the upper product bits.
// Depends on pca_pkg for the gain constant.
`default_nettype none
module pca_gain import pca_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] a,
  output logic [W-1:0] y
);
  localparam int H = W / 2;

  logic [H+31:0]   lo;
  logic [W-H+31:0] hi;
  logic [W+31:0]   sum;

  assign sum = ((W+32)'(hi) << H) + (W+32)'(lo);

  always_ff @(posedge clk) begin
    if (en) begin
      lo <= (H+32)'(a[H-1:0]) * (H+32)'(GAIN_Q32);
      hi <= (W-H+32)'(a[W-1:H]) * (W-H+32)'(GAIN_Q32);
      y  <= sum[W+31:32];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/pca_cordic.sv =====
// Pipelined CORDIC, one micro-rotation per stage, in rotation or vectoring mode.
// Depends on pca_pkg for the arctangent table.
`default_nettype none
module pca_cordic import pca_pkg::*; #(
  parameter int W      = 35,
  parameter int STAGES = 16,
  parameter bit VEC    = 1'b0
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] xi,
  input  logic signed [W-1:0] yi,
  input  logic [31:0]         zi,
  output logic signed [W-1:0] xo,
  output logic signed [W-1:0] yo,
  output logic [31:0]         zo
);
  logic signed [W-1:0] xs [0:STAGES];
  logic signed [W-1:0] ys [0:STAGES];
  logic [31:0]         zs [0:STAGES];

  assign xs[0] = xi;
  assign ys[0] = yi;
  assign zs[0] = zi;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic dir;
    assign dir = VEC ? ys[i][W-1] : !zs[i][31];
    always_ff @(posedge clk) begin
      if (en) begin
        if (dir) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_at(i);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_at(i);
        end
      end
    end
  end

  assign xo = xs[STAGES];
  assign yo = ys[STAGES];
  assign zo = zs[STAGES];
endmodule
`default_nettype wire

// ===== rtl/pca_front.sv =====
// Front end: takes requests, computes product or quotient modulus, classifies them.
// Depends on pca_pkg and pca_if; feeds the queue toward pca_back.
`default_nettype none
module pca_front import pca_pkg::*; #(
  parameter int MW = 32,
  parameter int AW = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  pca_req_if.sink                              req,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [$bits(cls_t)+5*MW+96:0]        out_data
);
  localparam int H  = MW / 2;
  localparam int QW = MW + FRAC_BITS;
  localparam int AS = 32 - AW;
  localparam int PW = 2 * MW;
  localparam logic [MW-1:0] MOD_MAX = '1;

  typedef struct packed {
    logic [2:0]         op;
    logic [MW-1:0]      xm;
    logic [MW-1:0]      ym;
    logic [31:0]        xa;
    logic [31:0]        ya;
    logic [MW-1:0]      cre;
    logic [MW-1:0]      cim;
    logic [MW+H-1:0]    pplo;
    logic [2*MW-H-1:0]  pphi;
    logic [MW-1:0]      rem;
    logic [QW-1:0]      q;
  } ft_t;

  typedef struct packed {
    cls_t          cls;
    logic          sub;
    logic [MW-1:0] m1;
    logic [MW-1:0] m2;
    logic [31:0]   z1;
    logic [31:0]   z2;
    logic [MW-1:0] cre;
    logic [MW-1:0] cim;
    logic [MW-1:0] pmod;
    logic [31:0]   pang;
  } qr_t;

  logic        en;
  logic [QW:0] vld;
  ft_t         st [0:QW];
  ft_t         s0;
  qr_t         qn;

  assign en        = !out_valid || out_ready;
  assign req.ready = en;

  always_comb begin
    s0      = '0;
    s0.op   = req.req_type;
    s0.xm   = req.x_mod;
    s0.ym   = req.y_mod;
    s0.xa   = {req.x_angle, {AS{1'b0}}};
    s0.ya   = {req.y_angle, {AS{1'b0}}};
    s0.cre  = req.cart_re;
    s0.cim  = req.cart_im;
    s0.pplo = (MW+H)'(req.x_mod) * (MW+H)'(req.y_mod[H-1:0]);
    s0.pphi = (2*MW-H)'(req.x_mod) * (2*MW-H)'(req.y_mod[MW-1:H]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[QW-1:0], req.valid};
      out_valid <= vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= s0;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    localparam int J = QW - k;
    logic        nb;
    logic [MW:0] rsh;
    logic [MW+1:0] dif;
    ft_t         nx;
    if (J >= FRAC_BITS) begin : g_bit
      assign nb = st[k-1].xm[J-FRAC_BITS];
    end else begin : g_zero
      assign nb = 1'b0;
    end
    assign rsh = {st[k-1].rem, nb};
    assign dif = {1'b0, rsh} - {2'b00, st[k-1].ym};
    always_comb begin
      nx     = st[k-1];
      nx.rem = dif[MW+1] ? rsh[MW-1:0] : dif[MW-1:0];
      nx.q   = {st[k-1].q[QW-2:0], !dif[MW+1]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= nx;
      end
    end
  end

  logic [PW-1:0] prod;
  logic [PW-1:0] psh;
  logic          msat;
  logic          dsat;
  ft_t           sl;

  assign sl   = st[QW];
  assign prod = (PW'(sl.pphi) << H) + PW'(sl.pplo);
  assign psh  = prod >> FRAC_BITS;
  assign msat = psh > PW'(MOD_MAX);
  assign dsat = sl.q > QW'(MOD_MAX);

  always_comb begin
    qn = '0;
    unique case (sl.op)
      OP_ADD, OP_SUB: begin
        qn.cls.kind = K_SUM;
        qn.sub      = (sl.op == OP_SUB);
        qn.m1       = sl.xm;
        qn.z1       = sl.xa;
        qn.m2       = sl.ym;
        qn.z2       = sl.ya;
      end
      OP_CART: begin
        qn.cls.kind = K_CART;
        qn.cre      = sl.cre;
        qn.cim      = sl.cim;
      end
      OP_MUL: begin
        qn.cls.kind = K_POLAR;
        qn.cls.sat  = msat;
        qn.pmod     = msat ? MOD_MAX : psh[MW-1:0];
        qn.pang     = sl.xa + sl.ya;
        qn.m1       = qn.pmod;
        qn.z1       = qn.pang;
      end
      OP_DIV: begin
        if (sl.ym == '0) begin
          qn.cls.kind = K_ZERO;
          qn.cls.div0 = 1'b1;
        end else begin
          qn.cls.kind = K_POLAR;
          qn.cls.sat  = dsat;
          qn.pmod     = dsat ? MOD_MAX : sl.q[MW-1:0];
          qn.pang     = sl.xa - sl.ya;
          qn.m1       = qn.pmod;
          qn.z1       = qn.pang;
        end
      end
      default: qn.cls.kind = K_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= qn;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/pca_fifo.sv =====
// Short request queue between the front and back ends.
// Standalone; holds opaque words of width W.
`default_nettype none
module pca_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         empty
);
  localparam int PTRW = $clog2(DEPTH);

  logic [W-1:0]    mem [0:DEPTH-1];
  logic [PTRW-1:0] wr_ptr;
  logic [PTRW-1:0] rd_ptr;
  logic [PTRW:0]   count;

  assign full  = count == (PTRW+1)'(DEPTH);
  assign empty = count == '0;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTRW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTRW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PTRW+1)'(push) - (PTRW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/pca_back.sv =====
// Back end: CORDIC rotations, add or subtract, vectoring, saturation, result register.
// Depends on pca_pkg, pca_if, pca_gain and pca_cordic.
`default_nettype none
module pca_back import pca_pkg::*; #(
  parameter int MW = 32,
  parameter int AW = 16,
  parameter int S  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [$bits(cls_t)+5*MW+96:0] in_data,
  pca_res_if.source                     res
);
  localparam int CW = MW + 3;
  localparam int SW = CW + 1;
  localparam int VW = SW + 2;
  localparam int AS = 32 - AW;
  localparam int KC = S + 4;
  localparam int KP = S + 5;
  localparam int KV = 2 * S + 5;
  localparam int KG = 2 * S + 7;
  localparam int KO = 2 * S + 8;
  localparam logic [MW-1:0] MOD_MAX = '1;
  localparam logic signed [SW-1:0] CMAX = {{(SW-MW+1){1'b0}}, {(MW-1){1'b1}}};
  localparam logic signed [SW-1:0] CMIN = ~CMAX;
  localparam logic [31:0] RND = 32'd1 << (AS - 1);

  typedef struct packed {
    cls_t          cls;
    logic          sub;
    logic [MW-1:0] m1;
    logic [MW-1:0] m2;
    logic [31:0]   z1;
    logic [31:0]   z2;
    logic [MW-1:0] cre;
    logic [MW-1:0] cim;
    logic [MW-1:0] pmod;
    logic [31:0]   pang;
  } qr_t;

  typedef struct packed {
    cls_t                cls;
    logic                sub;
    logic [31:0]         z1;
    logic [31:0]         z2;
    logic [MW-1:0]       pmod;
    logic [31:0]         pang;
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
    logic                zero;
  } side_t;

  logic    ben;
  logic [KO:1] vld;
  qr_t     qin;
  side_t   side [1:KO-1];

  assign qin      = qr_t'(in_data);
  assign ben      = !vld[KO] || res.ready;
  assign in_ready = ben;
  assign res.valid = vld[KO];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ben) begin
      vld <= {vld[KO-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      side[1].cls  <= qin.cls;
      side[1].sub  <= qin.sub;
      side[1].z1   <= qin.z1;
      side[1].z2   <= qin.z2;
      side[1].pmod <= qin.pmod;
      side[1].pang <= qin.pang;
      side[1].re   <= {{(SW-MW){qin.cre[MW-1]}}, qin.cre};
      side[1].im   <= {{(SW-MW){qin.cim[MW-1]}}, qin.cim};
      side[1].zero <= 1'b0;
    end
  end

  logic [MW-1:0] g1;
  logic [MW-1:0] g2;

  pca_gain #(.W(MW)) u_gain1 (.clk(clk), .en(ben), .a(qin.m1), .y(g1));
  pca_gain #(.W(MW)) u_gain2 (.clk(clk), .en(ben), .a(qin.m2), .y(g2));

  logic signed [CW-1:0] fx1;
  logic signed [CW-1:0] fx2;
  logic [31:0]          fz1;
  logic [31:0]          fz2;
  logic                 fl1;
  logic                 fl2;

  assign fl1 = side[2].z1[31] ^ side[2].z1[30];
  assign fl2 = side[2].z2[31] ^ side[2].z2[30];

  always_ff @(posedge clk) begin
    if (ben) begin
      fx1 <= fl1 ? -CW'(g1) : CW'(g1);
      fx2 <= fl2 ? -CW'(g2) : CW'(g2);
      fz1 <= fl1 ? side[2].z1 + 32'h80000000 : side[2].z1;
      fz2 <= fl2 ? side[2].z2 + 32'h80000000 : side[2].z2;
    end
  end

  logic signed [CW-1:0] r1x;
  logic signed [CW-1:0] r1y;
  logic signed [CW-1:0] r2x;
  logic signed [CW-1:0] r2y;
  logic [31:0]          r1z;
  logic [31:0]          r2z;

  pca_cordic #(.W(CW), .STAGES(S), .VEC(1'b0)) u_rot1 (
    .clk(clk), .en(ben), .xi(fx1), .yi('0), .zi(fz1), .xo(r1x), .yo(r1y), .zo(r1z)
  );
  pca_cordic #(.W(CW), .STAGES(S), .VEC(1'b0)) u_rot2 (
    .clk(clk), .en(ben), .xi(fx2), .yi('0), .zi(fz2), .xo(r2x), .yo(r2y), .zo(r2z)
  );

  logic signed [SW-1:0] e1x;
  logic signed [SW-1:0] e1y;
  logic signed [SW-1:0] e2x;
  logic signed [SW-1:0] e2y;

  assign e1x = {r1x[CW-1], r1x};
  assign e1y = {r1y[CW-1], r1y};
  assign e2x = {r2x[CW-1], r2x};
  assign e2y = {r2y[CW-1], r2y};

  logic signed [VW-1:0] px;
  logic signed [VW-1:0] py;
  logic [31:0]          pz;
  logic signed [VW-1:0] ex;
  logic signed [VW-1:0] ey;
  logic signed [VW-1:0] vx;
  logic signed [VW-1:0] vy;
  logic [31:0]          vz;

  assign ex = {{2{side[KP-1].re[SW-1]}}, side[KP-1].re};
  assign ey = {{2{side[KP-1].im[SW-1]}}, side[KP-1].im};

  always_ff @(posedge clk) begin
    if (ben) begin
      px <= ex[VW-1] ? -ex : ex;
      py <= ex[VW-1] ? -ey : ey;
      pz <= ex[VW-1] ? 32'h80000000 : 32'h0;
    end
  end

  pca_cordic #(.W(VW), .STAGES(S), .VEC(1'b1)) u_vec (
    .clk(clk), .en(ben), .xi(px), .yi(py), .zi(pz), .xo(vx), .yo(vy), .zo(vz)
  );

  for (genvar k = 2; k < KO; k++) begin : g_side
    side_t nx;
    always_comb begin
      nx = side[k-1];
      if (k == KC) begin
        unique case (side[k-1].cls.kind)
          K_SUM: begin
            nx.re = side[k-1].sub ? e1x - e2x : e1x + e2x;
            nx.im = side[k-1].sub ? e1y - e2y : e1y + e2y;
          end
          K_POLAR: begin
            nx.re = e1x;
            nx.im = e1y;
          end
          K_CART: begin
            nx.re = side[k-1].re;
            nx.im = side[k-1].im;
          end
          K_ZERO: begin
            nx.re = '0;
            nx.im = '0;
          end
        endcase
      end
      if (k == KP) begin
        nx.zero = (side[k-1].re == '0) && (side[k-1].im == '0);
      end
      if (k == KV + 1) begin
        if (side[k-1].cls.kind == K_SUM || side[k-1].cls.kind == K_CART) begin
          nx.pang = side[k-1].zero ? 32'h0 : vz;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (ben) begin
        side[k] <= nx;
      end
    end
  end

  logic [VW-2:0] mag_in;
  logic [VW-2:0] mag;

  assign mag_in = vx[VW-1] ? '0 : vx[VW-2:0];

  pca_gain #(.W(VW-1)) u_gain_mag (.clk(clk), .en(ben), .a(mag_in), .y(mag));

  side_t         sf;
  logic          re_hi;
  logic          re_lo;
  logic          im_hi;
  logic          im_lo;
  logic          mag_sat;
  logic [31:0]   ang_r;
  logic [MW-1:0] mod_n;
  logic [AW-1:0] ang_n;
  logic [MW-1:0] re_n;
  logic [MW-1:0] im_n;
  status_t       st_n;
  logic          sat_any;

  assign sf      = side[KG];
  assign re_hi   = sf.re > CMAX;
  assign re_lo   = sf.re < CMIN;
  assign im_hi   = sf.im > CMAX;
  assign im_lo   = sf.im < CMIN;
  assign mag_sat = mag > (VW-1)'(MOD_MAX);
  assign ang_r   = sf.pang + RND;

  always_comb begin
    re_n    = re_hi ? CMAX[MW-1:0] : (re_lo ? CMIN[MW-1:0] : sf.re[MW-1:0]);
    im_n    = im_hi ? CMAX[MW-1:0] : (im_lo ? CMIN[MW-1:0] : sf.im[MW-1:0]);
    ang_n   = ang_r[31:AS];
    sat_any = re_hi || re_lo || im_hi || im_lo;
    mod_n   = '0;
    st_n    = ST_OK;
    unique case (sf.cls.kind)
      K_SUM, K_CART: begin
        if (!sf.zero) begin
          mod_n   = mag_sat ? MOD_MAX : mag[MW-1:0];
          sat_any = sat_any || mag_sat;
        end
        st_n = sat_any ? ST_SAT : ST_OK;
      end
      K_POLAR: begin
        mod_n = sf.pmod;
        st_n  = (sat_any || sf.cls.sat) ? ST_SAT : ST_OK;
      end
      K_ZERO: begin
        re_n  = '0;
        im_n  = '0;
        ang_n = '0;
        st_n  = sf.cls.div0 ? ST_DIV0 : ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      res.res_mod   <= mod_n;
      res.res_angle <= ang_n;
      res.res_re    <= re_n;
      res.res_im    <= im_n;
      res.status    <= st_n;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/polar_complex_alu.sv =====
// Requests pass through the one-bit-per-stage divider in the front end, the queue and the
// three CORDIC pipelines in the back end. Throughput: one request per cycle unless stalled;
// a stalled result holds the back end and the queue; a full queue holds the front end.
// Reset clears the valid bits and empties the queue; datapath registers are not reset.
// Depends on pca_pkg, pca_if, pca_front, pca_fifo and pca_back.
`default_nettype none
module polar_complex_alu import pca_pkg::*; #(
  parameter int MOD_WIDTH     = 32,
  parameter int ANGLE_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic      clk,
  input  logic      rst,
  pca_req_if.sink   req,
  pca_res_if.source res
);
  localparam int QPW = $bits(cls_t) + 5 * MOD_WIDTH + 97;

  logic           f_valid;
  logic [QPW-1:0] f_data;
  logic [QPW-1:0] q_data;
  logic           q_full;
  logic           q_empty;
  logic           b_ready;

  pca_front #(.MW(MOD_WIDTH), .AW(ANGLE_WIDTH)) u_front (
    .clk(clk), .rst(rst), .req(req),
    .out_valid(f_valid), .out_ready(!q_full), .out_data(f_data)
  );

  pca_fifo #(.W(QPW), .DEPTH(4)) u_queue (
    .clk(clk), .rst(rst),
    .push(f_valid && !q_full), .din(f_data),
    .pop(!q_empty && b_ready), .dout(q_data),
    .full(q_full), .empty(q_empty)
  );

  pca_back #(.MW(MOD_WIDTH), .AW(ANGLE_WIDTH), .S(CORDIC_STAGES)) u_back (
    .clk(clk), .rst(rst),
    .in_valid(!q_empty), .in_ready(b_ready), .in_data(q_data),
    .res(res)
  );
endmodule
`default_nettype wire

// ===== rtl/pca_check.sv =====
// Port-level checker for the polar complex ALU, bound to the top level.
// Depends on pca_pkg and polar_complex_alu_macros.svh.
`default_nettype none
`include "polar_complex_alu_macros.svh"
module pca_check import pca_pkg::*; #(
  parameter int MW = 32,
  parameter int AW = 16
) (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          res_valid,
  input wire logic          res_ready,
  input wire logic [MW-1:0] res_mod,
  input wire logic [AW-1:0] res_angle,
  input wire logic [MW-1:0] res_re,
  input wire logic [MW-1:0] res_im,
  input wire logic [1:0]    res_status
);
  `PCA_AS_NXT(a_res_hold, res_valid && !res_ready, res_valid)
  `PCA_AS_RST(a_reset_empty, rst, !res_valid)
  `PCA_AS_IMP(a_div0_zero, res_valid && res_status == ST_DIV0, res_mod == '0 && res_angle == '0 && res_re == '0 && res_im == '0)
endmodule

bind polar_complex_alu pca_check #(.MW(MOD_WIDTH), .AW(ANGLE_WIDTH)) u_check (
  .clk(clk), .rst(rst),
  .res_valid(res.valid), .res_ready(res.ready),
  .res_mod(res.res_mod), .res_angle(res.res_angle),
  .res_re(res.res_re), .res_im(res.res_im), .res_status(res.status)
);
`default_nettype wire
